/* rtl/core/scc_pkg.sv */
// ----------------------------------------------------------------------------
// scc_pkg
// Shared widths and item codes for the strongly connected components core.
// ----------------------------------------------------------------------------
package scc_pkg;

  // field widths
  localparam int unsigned VertW  = 6;
  localparam int unsigned CompW  = 7;
  localparam int unsigned ActW   = 2;
  localparam int unsigned VCntW  = 7;
  localparam int unsigned NumVis = 2 ** VertW;

  // largest graph, tied to the vertex field width
  localparam int unsigned MaxVertices = 2 ** VertW;

  // action codes carried on the input tuser
  typedef enum logic [ActW-1:0] {
    ACT_ADD   = 2'd0,
    ACT_RUN   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

endpackage

/* rtl/core/scc_ram.sv */
// ----------------------------------------------------------------------------
// scc_ram
// Simple dual-port memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module scc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                       rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/strongly_connected_components_core.sv */
// ----------------------------------------------------------------------------
// strongly_connected_components_core
// Kosaraju component search over a loaded edge list, one vertex reported
// per output item with its component number.
// ----------------------------------------------------------------------------
// channel   dir  handshake             payload
// s_axis    in   tvalid/tready         tuser action, tdata src,dst
// m_axis    out  tvalid/tready         tdata vertex,component; tlast; tuser overflow
// cfg       in   cfg_we_i              cfg_wdata_i vertex_count
//
// add and clear items are taken while idle; an add to a full store gives one item
// a run walks the edge memory through one read port
// reset clears the control state and sets vertex_count to 64; the edge memory needs no clearing pass
// pass two stalls before emitting a vertex while a finished item waits on m_axis_tready_i
// ----------------------------------------------------------------------------
module strongly_connected_components_core
  import scc_pkg::*;
#(
  parameter int unsigned MAX_EDGES    = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  logic [1:0]       s_axis_tuser_i,   // action
  input  logic [15:0]      s_axis_tdata_i,   // src, dst, zero fill
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // vertex, component, zero fill
  output logic             m_axis_tlast_o,
  output logic             m_axis_tuser_o,   // overflow
  input  logic             cfg_we_i,
  input  logic [VCntW-1:0] cfg_wdata_i       // vertex_count
);

  localparam int unsigned EcW = $clog2(MAX_EDGES + 1);
  localparam int unsigned EaW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned SdW = $clog2(MaxVertices + 1);
  localparam int unsigned SaW = $clog2(MaxVertices);
  localparam int unsigned WsW = VertW + EcW;

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_P1_ST = 10'b0000000010,
    ST_P1_RD = 10'b0000000100,
    ST_P1_EV = 10'b0000001000,
    ST_P1_PO = 10'b0000010000,
    ST_P2_RT = 10'b0000100000,
    ST_P2_R2 = 10'b0001000000,
    ST_P2_RD = 10'b0010000000,
    ST_P2_EV = 10'b0100000000,
    ST_P2_PO = 10'b1000000000
  } state_e;

  state_e              state_q, state_d;
  logic [VCntW-1:0]    vcount_q, n_q, n_d;
  logic [EcW-1:0]      ecount_q, ecount_d;
  logic [VCntW-1:0]    s_q, s_d;
  logic [VertW-1:0]    cur_v_q, cur_v_d;
  logic [EcW-1:0]      cur_k_q, cur_k_d;
  logic [SdW-1:0]      depth_q, depth_d;
  logic [SdW-1:0]      ftop_q, ftop_d;
  logic [VertW-1:0]    best_q, best_d;
  logic                best_vld_q, best_vld_d;
  logic [CompW-1:0]    comp_q, comp_d;
  logic [VCntW-1:0]    emit_cnt_q, emit_cnt_d;
  logic [NumVis-1:0]   visited_q, visited_d;

  logic                out_vld_q, out_vld_d;
  logic [VertW-1:0]    out_vert_q, out_vert_d;
  logic [CompW-1:0]    out_comp_q, out_comp_d;
  logic                out_last_q, out_last_d;
  logic                out_ovf_q, out_ovf_d;

  // memory ports
  logic                e_we, e_re;
  logic [EaW-1:0]      e_raddr;
  logic [2*VertW-1:0]  e_rdata;
  logic                w_we, w_re;
  logic [SaW-1:0]      w_waddr, w_raddr;
  logic [WsW-1:0]      w_wdata, w_rdata;
  logic                f_we, f_re;
  logic [SaW-1:0]      f_waddr, f_raddr;
  logic [VertW-1:0]    f_wdata, f_rdata;

  logic                in_acc, out_free;
  logic [VertW-1:0]    in_src, in_dst, e_src, e_dst;
  logic [VCntW-1:0]    n_run;

  assign in_src   = s_axis_tdata_i[VertW-1:0];
  assign in_dst   = s_axis_tdata_i[2*VertW-1:VertW];
  assign e_src    = e_rdata[VertW-1:0];
  assign e_dst    = e_rdata[2*VertW-1:VertW];
  assign out_free = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign n_run    = ({25'd0, vcount_q} > MaxVertices) ? VCntW'(MaxVertices) : vcount_q;

  scc_ram #(.Width(2 * VertW), .Depth(MAX_EDGES)) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (e_we),
    .waddr_i (ecount_q[EaW-1:0]),
    .wdata_i ({in_dst, in_src}),
    .re_i    (e_re),
    .raddr_i (e_raddr),
    .rdata_o (e_rdata)
  );

  scc_ram #(.Width(WsW), .Depth(MaxVertices)) u_walk_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (w_wdata),
    .re_i    (w_re),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  scc_ram #(.Width(VertW), .Depth(MaxVertices)) u_finish_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (f_re),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  // sequencer for both passes
  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    ecount_d   = ecount_q;
    s_d        = s_q;
    cur_v_d    = cur_v_q;
    cur_k_d    = cur_k_q;
    depth_d    = depth_q;
    ftop_d     = ftop_q;
    best_d     = best_q;
    best_vld_d = best_vld_q;
    comp_d     = comp_q;
    emit_cnt_d = emit_cnt_q;
    visited_d  = visited_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    out_vert_d = out_vert_q;
    out_comp_d = out_comp_q;
    out_last_d = out_last_q;
    out_ovf_d  = out_ovf_q;
    e_we = 1'b0; e_re = 1'b0; e_raddr = cur_k_q[EaW-1:0];
    w_we = 1'b0; w_re = 1'b0;
    w_waddr = depth_q[SaW-1:0];
    w_raddr = SaW'(depth_q - 1'b1);
    w_wdata = {EcW'(cur_k_q + 1'b1), cur_v_q};
    f_we = 1'b0; f_re = 1'b0;
    f_waddr = ftop_q[SaW-1:0];
    f_raddr = SaW'(ftop_q - 1'b1);
    f_wdata = cur_v_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (action_e'(s_axis_tuser_i))
            ACT_ADD: begin
              if (ecount_q == EcW'(MAX_EDGES)) begin
                out_vld_d  = 1'b1;
                out_vert_d = '0;
                out_comp_d = '0;
                out_last_d = 1'b0;
                out_ovf_d  = 1'b1;
              end else begin
                e_we     = 1'b1;
                ecount_d = ecount_q + 1'b1;
              end
            end
            ACT_CLEAR: ecount_d = '0;
            ACT_RUN: begin
              if (n_run != '0) begin
                n_d       = n_run;
                s_d       = '0;
                ftop_d    = '0;
                visited_d = '0;
                state_d   = ST_P1_ST;
              end
            end
            ACT_NONE: ;
            default: ;
          endcase
        end
      end
      // pick the next unvisited start vertex, or start pass two once all are tried
      ST_P1_ST: begin
        if (s_q == n_q) begin
          visited_d  = '0;
          comp_d     = CompW'(1);
          emit_cnt_d = '0;
          state_d    = ST_P2_RT;
        end else if (visited_q[s_q[VertW-1:0]]) begin
          s_d = s_q + 1'b1;
        end else begin
          visited_d[s_q[VertW-1:0]] = 1'b1;
          cur_v_d = s_q[VertW-1:0];
          cur_k_d = '0;
          depth_d = '0;
          state_d = ST_P1_RD;
        end
      end
      // fetch the next edge or finish the vertex
      ST_P1_RD: begin
        if (cur_k_q == ecount_q) begin
          f_we   = 1'b1;
          ftop_d = ftop_q + 1'b1;
          if (depth_q == '0) begin
            s_d     = s_q + 1'b1;
            state_d = ST_P1_ST;
          end else begin
            w_re    = 1'b1;
            depth_d = depth_q - 1'b1;
            state_d = ST_P1_PO;
          end
        end else begin
          e_re    = 1'b1;
          state_d = ST_P1_RD == state_q ? ST_P1_EV : state_q;
        end
      end
      // follow the edge if it leaves the current vertex for an unvisited vertex in range
      ST_P1_EV: begin
        cur_k_d = cur_k_q + 1'b1;
        state_d = ST_P1_RD;
        if (e_src == cur_v_q && {1'b0, e_dst} < n_q && !visited_q[e_dst]) begin
          visited_d[e_dst] = 1'b1;
          w_we    = 1'b1;
          depth_d = depth_q + 1'b1;
          cur_v_d = e_dst;
          cur_k_d = '0;
        end
      end
      ST_P1_PO: begin
        cur_v_d = w_rdata[VertW-1:0];
        cur_k_d = w_rdata[WsW-1:VertW];
        state_d = ST_P1_RD;
      end
      // pop the next root from the finish order, or return to idle when it is empty
      ST_P2_RT: begin
        if (ftop_q == '0) begin
          state_d = ST_IDLE;
        end else begin
          f_re    = 1'b1;
          ftop_d  = ftop_q - 1'b1;
          state_d = ST_P2_R2;
        end
      end
      ST_P2_R2: begin
        if ({1'b0, f_rdata} >= n_q || visited_q[f_rdata]) begin
          state_d = ST_P2_RT;
        end else if (out_free) begin
          visited_d[f_rdata] = 1'b1;
          out_vld_d  = 1'b1;
          out_vert_d = f_rdata;
          out_comp_d = comp_q;
          out_last_d = (emit_cnt_q + 1'b1) == n_q;
          out_ovf_d  = 1'b0;
          emit_cnt_d = emit_cnt_q + 1'b1;
          cur_v_d    = f_rdata;
          cur_k_d    = '0;
          best_vld_d = 1'b0;
          depth_d    = '0;
          state_d    = ST_P2_RD;
        end
      end
      // scan all edges for the lowest unvisited predecessor, then visit it or step back
      ST_P2_RD: begin
        if (cur_k_q != ecount_q) begin
          e_re    = 1'b1;
          state_d = ST_P2_EV;
        end else if (best_vld_q) begin
          if (out_free) begin
            visited_d[best_q] = 1'b1;
            out_vld_d  = 1'b1;
            out_vert_d = best_q;
            out_comp_d = comp_q;
            out_last_d = (emit_cnt_q + 1'b1) == n_q;
            out_ovf_d  = 1'b0;
            emit_cnt_d = emit_cnt_q + 1'b1;
            w_we       = 1'b1;
            w_wdata    = {{EcW{1'b0}}, cur_v_q};
            depth_d    = depth_q + 1'b1;
            cur_v_d    = best_q;
            cur_k_d    = '0;
            best_vld_d = 1'b0;
          end
        end else if (depth_q == '0) begin
          comp_d  = comp_q + 1'b1;
          state_d = ST_P2_RT;
        end else begin
          w_re    = 1'b1;
          depth_d = depth_q - 1'b1;
          state_d = ST_P2_PO;
        end
      end
      ST_P2_EV: begin
        cur_k_d = cur_k_q + 1'b1;
        state_d = ST_P2_RD;
        if (e_dst == cur_v_q && {1'b0, e_src} < n_q && !visited_q[e_src] &&
            (!best_vld_q || e_src < best_q)) begin
          best_d     = e_src;
          best_vld_d = 1'b1;
        end
      end
      ST_P2_PO: begin
        cur_v_d    = w_rdata[VertW-1:0];
        cur_k_d    = '0;
        best_vld_d = 1'b0;
        state_d    = ST_P2_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      vcount_q   <= VCntW'(64);
      n_q        <= '0;
      ecount_q   <= '0;
      s_q        <= '0;
      cur_v_q    <= '0;
      cur_k_q    <= '0;
      depth_q    <= '0;
      ftop_q     <= '0;
      best_q     <= '0;
      best_vld_q <= 1'b0;
      comp_q     <= CompW'(1);
      emit_cnt_q <= '0;
      visited_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      n_q        <= n_d;
      ecount_q   <= ecount_d;
      s_q        <= s_d;
      cur_v_q    <= cur_v_d;
      cur_k_q    <= cur_k_d;
      depth_q    <= depth_d;
      ftop_q     <= ftop_d;
      best_q     <= best_d;
      best_vld_q <= best_vld_d;
      comp_q     <= comp_d;
      emit_cnt_q <= emit_cnt_d;
      visited_q  <= visited_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    out_vert_q <= out_vert_d;
    out_comp_q <= out_comp_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {3'b000, out_comp_q, out_vert_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_ovf_q;

endmodule
